// ----- design/dprc_pkg.sv -----
// ----------------------------------------------------------------------------
// dprc_pkg
// Shared types and constants for the dirty page row coalescer.
// ----------------------------------------------------------------------------
package dprc_pkg;

   // Default tuning values for the top level parameters
   localparam int PAGE_BYTES_DEF     = 4096;
   localparam int MERGE_GAP_ROWS_DEF = 3;
   localparam int MAX_ROWS_DEF       = 4096;

   // Bitmap word geometry
   localparam int WORD_BITS  = 32;
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int WORD_IDX_W = 16;
   localparam int PAGE_W     = WORD_IDX_W + BIT_IDX_W;

   // Row and register widths
   localparam int STRIDE_W   = 15;
   localparam int ROW_W      = 13;
   localparam int START_W    = 12;
   localparam int QUOT_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Register reset values
   localparam logic [STRIDE_W-1:0] STRIDE_RST  = 15'd2560;
   localparam logic [ROW_W-1:0]    ROWS_RST    = 13'd480;
   localparam logic [ROW_W-1:0]    COLUMNS_RST = 13'd640;

   // Request queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_STRIDE    = 2'd0,
      CSR_SCREEN_ROWS    = 2'd1,
      CSR_SCREEN_COLUMNS = 2'd2
   } csr_index_type;

   // One queued request: the bitmap word and its position in the scan
   typedef struct packed {
      logic [WORD_BITS-1:0]  dirty_word;
      logic                  last_word;
      logic [WORD_IDX_W-1:0] word_index;
   } req_entry_type;

   // Divider status toward the back end
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_MUL,
      BK_START,
      BK_DIVW,
      BK_MERGE,
      BK_WEND,
      BK_FINAL
   } back_state_type;

endpackage

// ----- design/dprc_fifo.sv -----
// ----------------------------------------------------------------------------
// dprc_fifo
// Short request queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dprc_fifo
   import dprc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  req_entry_type push_data,
   input  logic          pop,
   output req_entry_type head,
   output logic          empty,
   output logic          full
);

   req_entry_type        slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step with count");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count lost a pop");

endmodule

// ----- design/dprc_front.sv -----
// ----------------------------------------------------------------------------
// dprc_front
// Request acceptance: tags each bitmap word with its index in the scan and
// hands it to the queue.
// ----------------------------------------------------------------------------
module dprc_front
   import dprc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_dirty_word,
   input  logic                 req_last_word,
   input  logic                 q_full,
   output logic                 q_push,
   output req_entry_type        q_data
);

   logic [WORD_IDX_W-1:0] word_idx_ff, word_idx_in;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_data.dirty_word = req_dirty_word;
      q_data.last_word  = req_last_word;
      q_data.word_index = word_idx_ff;
   end

   // Word index: restarts after the last word of a scan, wraps otherwise
   always_comb begin
      word_idx_in = word_idx_ff;
      if (q_push) begin
         word_idx_in = req_last_word ? '0 : word_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_idx_ff <= '0;
      end else begin
         word_idx_ff <= word_idx_in;
      end
   end

   // Assertions
   a_idx_clear: assert property (@(posedge clock) disable iff (reset)
      q_push && req_last_word |=> (word_idx_ff == '0))
      else $error("word index not cleared after last word");

   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      !q_push |=> $stable(word_idx_ff))
      else $error("word index moved without a request");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      q_push && !req_last_word |=> (word_idx_ff == $past(word_idx_ff) + 1'b1))
      else $error("word index did not advance");

endmodule

// ----- design/dprc_div.sv -----
// ----------------------------------------------------------------------------
// dprc_div
// Dual restoring divider: divides two byte offsets by the line stride, one
// quotient bit per cycle. Quotients saturate to all ones when they do not
// fit, which is always beyond any visible row.
// ----------------------------------------------------------------------------
module dprc_div
   import dprc_pkg::*;
#(
   parameter int DIVIDEND_W = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend_a,
   input  logic [DIVIDEND_W-1:0] dividend_b,
   input  logic [STRIDE_W-1:0]   divisor,
   output div_stat_type          stat,
   output logic [QUOT_W-1:0]     quot_a,
   output logic [QUOT_W-1:0]     quot_b
);

   localparam int HI_W  = DIVIDEND_W - QUOT_W;
   localparam int REM_W = STRIDE_W + 1;
   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic                busy_ff, done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [STRIDE_W-1:0] rem_a_ff, rem_b_ff;
   logic [QUOT_W-1:0]   low_a_ff, low_b_ff;
   logic [QUOT_W-1:0]   q_a_ff, q_b_ff;
   logic                sat_a_ff, sat_b_ff;

   logic                sat_a_in, sat_b_in;
   logic [REM_W-1:0]    sh_a, sh_b;
   logic                ge_a, ge_b;
   logic [REM_W-1:0]    diff_a, diff_b;

   // Overflow check: quotient needs more than QUOT_W bits
   assign sat_a_in = dividend_a[DIVIDEND_W-1:QUOT_W] >= HI_W'(divisor);
   assign sat_b_in = dividend_b[DIVIDEND_W-1:QUOT_W] >= HI_W'(divisor);

   // One restoring step on each dividend
   assign sh_a   = {rem_a_ff, low_a_ff[QUOT_W-1]};
   assign sh_b   = {rem_b_ff, low_b_ff[QUOT_W-1]};
   assign ge_a   = sh_a >= REM_W'(divisor);
   assign ge_b   = sh_b >= REM_W'(divisor);
   assign diff_a = ge_a ? sh_a - REM_W'(divisor) : sh_a;
   assign diff_b = ge_b ? sh_b - REM_W'(divisor) : sh_b;

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot_a    = sat_a_ff ? '1 : q_a_ff;
   assign quot_b    = sat_b_ff ? '1 : q_b_ff;

   // Step counter and status
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainders and quotient bits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_a_ff <= dividend_a[QUOT_W +: STRIDE_W];
         rem_b_ff <= dividend_b[QUOT_W +: STRIDE_W];
         low_a_ff <= dividend_a[QUOT_W-1:0];
         low_b_ff <= dividend_b[QUOT_W-1:0];
         sat_a_ff <= sat_a_in;
         sat_b_ff <= sat_b_in;
         q_a_ff   <= '0;
         q_b_ff   <= '0;
      end else if (busy_ff) begin
         rem_a_ff <= diff_a[STRIDE_W-1:0];
         rem_b_ff <= diff_b[STRIDE_W-1:0];
         low_a_ff <= {low_a_ff[QUOT_W-2:0], 1'b0};
         low_b_ff <= {low_b_ff[QUOT_W-2:0], 1'b0};
         q_a_ff   <= {q_a_ff[QUOT_W-2:0], ge_a};
         q_b_ff   <= {q_b_ff[QUOT_W-2:0], ge_b};
      end
   end

   // Assertions
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");

endmodule

// ----- design/dprc_back.sv -----
// ----------------------------------------------------------------------------
// dprc_back
// Back end: walks the set bits of a queued word, maps each page to a row
// span through the divider, merges spans into the open region and emits
// update rectangles through a one-deep hold stage and the output register.
// ----------------------------------------------------------------------------
module dprc_back
   import dprc_pkg::*;
#(
   parameter int PAGE_BYTES     = PAGE_BYTES_DEF,
   parameter int MERGE_GAP_ROWS = MERGE_GAP_ROWS_DEF,
   parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  req_entry_type       q_head,
   output logic                q_pop,
   input  logic [STRIDE_W-1:0] line_stride,
   input  logic [ROW_W-1:0]    screen_rows,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [START_W-1:0]  rsp_row_start,
   output logic [ROW_W-1:0]    rsp_row_count,
   output logic                rsp_last_of_run
);

   localparam int DIVIDEND_W = PAGE_W + $clog2(PAGE_BYTES + 1);
   localparam int SPAN_W     = ROW_W + 1;

   back_state_type state_ff, state_in;

   // Current word
   logic [WORD_BITS-1:0]  word_ff;
   logic                  last_ff;
   logic [WORD_IDX_W-1:0] widx_ff;
   logic [BIT_IDX_W-1:0]  bit_ff;

   // Page byte offset
   logic [DIVIDEND_W-1:0] byte_lo_ff;
   logic [DIVIDEND_W-1:0] byte_hi;
   logic [PAGE_W-1:0]     page_num;

   // Open region, held rectangle, output register
   logic [ROW_W-1:0]      region_first_ff, region_end_ff;
   logic                  pend_valid_ff;
   logic [ROW_W-1:0]      pend_first_ff, pend_end_ff;
   logic                  rsp_valid_ff;
   logic [START_W-1:0]    row_start_ff;
   logic [ROW_W-1:0]      row_count_ff;
   logic                  last_run_ff;

   // Divider
   div_stat_type          div_stat;
   logic                  div_start;
   logic [STRIDE_W-1:0]   stride_eff;
   logic [QUOT_W-1:0]     quot_a, quot_b;

   // Span math
   logic [ROW_W-1:0]      rows_eff;
   logic [ROW_W-1:0]      new_y0, new_y1;
   logic [SPAN_W-1:0]     y1_raw;
   logic                  page_ok, region_empty, can_merge;
   logic                  bit_hit, bit_last, out_free;
   logic                  need_flush, wend_flush;
   logic                  stall_merge, stall_wend, stall_final;

   // Sequencer strobes
   logic                  scan_adv, mul_go, merge_go, wend_go, final_go;
   logic                  flush_now, out_load;

   assign stride_eff = (line_stride == '0) ? STRIDE_W'(1) : line_stride;
   assign rows_eff   = (screen_rows > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : screen_rows;

   assign page_num = {widx_ff, bit_ff};
   assign byte_hi  = byte_lo_ff + DIVIDEND_W'(PAGE_BYTES - 1);

   dprc_div #(
      .DIVIDEND_W(DIVIDEND_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend_a(byte_lo_ff),
      .dividend_b(byte_hi),
      .divisor   (stride_eff),
      .stat      (div_stat),
      .quot_a    (quot_a),
      .quot_b    (quot_b)
   );

   // Row span of the page, end clamped to the screen
   assign new_y0  = quot_a;
   assign y1_raw  = SPAN_W'(quot_b) + 1'b1;
   assign new_y1  = (y1_raw > SPAN_W'(rows_eff)) ? rows_eff : y1_raw[ROW_W-1:0];
   assign page_ok = new_y0 < rows_eff;

   assign region_empty = (region_first_ff == region_end_ff);
   assign can_merge    = SPAN_W'(new_y0) <= SPAN_W'(region_end_ff) + SPAN_W'(MERGE_GAP_ROWS);

   assign bit_hit  = word_ff[bit_ff];
   assign bit_last = (bit_ff == BIT_IDX_W'(WORD_BITS - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Held rectangle can only move on when the output register is free
   assign need_flush  = page_ok && !region_empty && !can_merge;
   assign wend_flush  = last_ff && !region_empty;
   assign stall_merge = need_flush && pend_valid_ff && !out_free;
   assign stall_wend  = wend_flush && pend_valid_ff && !out_free;
   assign stall_final = pend_valid_ff && !out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) state_in = BK_SCAN;
         end
         BK_SCAN: begin
            if (bit_hit) state_in = BK_MUL;
            else if (bit_last) state_in = BK_WEND;
         end
         BK_MUL: state_in = BK_START;
         BK_START: state_in = BK_DIVW;
         BK_DIVW: begin
            if (div_stat.done) state_in = BK_MERGE;
         end
         BK_MERGE: begin
            if (!stall_merge) state_in = bit_last ? BK_WEND : BK_SCAN;
         end
         BK_WEND: begin
            if (!stall_wend) state_in = BK_FINAL;
         end
         BK_FINAL: begin
            if (!stall_final) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      q_pop     = 1'b0;
      scan_adv  = 1'b0;
      mul_go    = 1'b0;
      div_start = 1'b0;
      merge_go  = 1'b0;
      wend_go   = 1'b0;
      final_go  = 1'b0;
      case (state_ff)
         BK_IDLE:  q_pop     = !q_empty;
         BK_SCAN:  scan_adv  = !bit_hit && !bit_last;
         BK_MUL:   mul_go    = 1'b1;
         BK_START: div_start = 1'b1;
         BK_MERGE: merge_go  = !stall_merge;
         BK_WEND:  wend_go   = !stall_wend;
         BK_FINAL: final_go  = !stall_final;
         default: begin
         end
      endcase
   end

   assign flush_now = (merge_go && need_flush) || (wend_go && wend_flush);
   assign out_load  = (flush_now || final_go) && pend_valid_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BK_IDLE;
         region_first_ff <= '0;
         region_end_ff   <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Open region
         if (merge_go && page_ok) begin
            if (region_empty || !can_merge) begin
               region_first_ff <= new_y0;
               region_end_ff   <= new_y1;
            end else begin
               if (new_y0 < region_first_ff) region_first_ff <= new_y0;
               if (new_y1 > region_end_ff) region_end_ff <= new_y1;
            end
         end else if (wend_go && last_ff) begin
            region_first_ff <= '0;
            region_end_ff   <= '0;
         end

         // Held rectangle
         if (flush_now) begin
            pend_valid_ff <= 1'b1;
         end else if (final_go) begin
            pend_valid_ff <= 1'b0;
         end

         // Output register
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         word_ff <= q_head.dirty_word;
         last_ff <= q_head.last_word;
         widx_ff <= q_head.word_index;
         bit_ff  <= '0;
      end else if (scan_adv || (merge_go && !bit_last)) begin
         bit_ff <= bit_ff + 1'b1;
      end
      if (mul_go) begin
         byte_lo_ff <= DIVIDEND_W'(page_num) * DIVIDEND_W'(PAGE_BYTES);
      end
      if (flush_now) begin
         pend_first_ff <= region_first_ff;
         pend_end_ff   <= region_end_ff;
      end
      if (out_load) begin
         row_start_ff <= pend_first_ff[START_W-1:0];
         row_count_ff <= pend_end_ff - pend_first_ff;
         last_run_ff  <= final_go;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_start   = row_start_ff;
   assign rsp_row_count   = row_count_ff;
   assign rsp_last_of_run = last_run_ff;

   // Assertions
   a_region_order: assert property (@(posedge clock) disable iff (reset)
      region_first_ff <= region_end_ff)
      else $error("open region ends before it starts");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (row_count_ff != '0))
      else $error("empty rectangle on output");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE) |-> !pend_valid_ff)
      else $error("held rectangle left behind after a word");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == BK_DIVW))
      else $error("divider finished outside its wait state");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FINAL) && last_ff |-> (region_first_ff == '0) && (region_end_ff == '0))
      else $error("region not cleared at end of scan");

endmodule

// ----- design/dirty_page_row_coalescer.sv -----
// ----------------------------------------------------------------------------
// dirty_page_row_coalescer
// Turns a frame buffer page dirty bitmap into coalesced full-width update
// rectangles, one 32-bit bitmap word per request.
// ----------------------------------------------------------------------------
// Throughput is set by the scan of the word, one bit per cycle while no set
// bit holds it, and by the 13-step shared divider that maps each page to
// rows; a stalled response channel holds the back end as well. A two-entry
// queue lets new requests in while a word is being worked.
// Reset (synchronous, active high) clears the queue, word index, region and
// output; stride, rows and columns return to 2560, 480 and 640.
module dirty_page_row_coalescer
   import dprc_pkg::*;
#(
   parameter int PAGE_BYTES     = PAGE_BYTES_DEF,
   parameter int MERGE_GAP_ROWS = MERGE_GAP_ROWS_DEF,
   parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_BITS-1:0]  req_dirty_word,
   input  logic                  req_last_word,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [START_W-1:0]    rsp_row_start,
   output logic [ROW_W-1:0]      rsp_row_count,
   output logic [ROW_W-1:0]      rsp_rect_width,
   output logic                  rsp_last_of_run,
   // Register write port
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [STRIDE_W-1:0] stride_ff;
   logic [ROW_W-1:0]    rows_ff;
   logic [ROW_W-1:0]    columns_ff;

   logic                q_push, q_pop, q_empty, q_full;
   req_entry_type       q_data, q_head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff  <= STRIDE_RST;
         rows_ff    <= ROWS_RST;
         columns_ff <= COLUMNS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LINE_STRIDE:    stride_ff  <= csr_write_data;
            CSR_SCREEN_ROWS:    rows_ff    <= csr_write_data[ROW_W-1:0];
            CSR_SCREEN_COLUMNS: columns_ff <= csr_write_data[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_rect_width = columns_ff;

   dprc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_dirty_word(req_dirty_word),
      .req_last_word (req_last_word),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_data)
   );

   dprc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_data),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   dprc_back #(
      .PAGE_BYTES    (PAGE_BYTES),
      .MERGE_GAP_ROWS(MERGE_GAP_ROWS),
      .MAX_ROWS      (MAX_ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .line_stride    (stride_ff),
      .screen_rows    (rows_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_start  (rsp_row_start),
      .rsp_row_count  (rsp_row_count),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dirty page row coalescer. Bitmap words are
// sent over the request channel and every update rectangle is compared with
// a local page-to-row model. Directed checks cover edge geometries, merge
// gap edges, pages below the screen and clamps. Random scans follow under
// several register settings, with bursty requests, receiver stalls and a
// long backpressure stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import dprc_pkg::*;

   // Cycles to let the block settle with no response pending
   localparam int SETTLE_CYCLES = 2500;

   typedef struct {
      logic [START_W-1:0] row_start;
      logic [ROW_W-1:0]   row_count;
      logic [ROW_W-1:0]   rect_width;
      logic               last_of_run;
   } rect_type;

   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_EVERY_FOURTH,
      RDY_SPARSE
   } ready_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [WORD_BITS-1:0]  req_dirty_word;
   logic                  req_last_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [START_W-1:0]    rsp_row_start;
   logic [ROW_W-1:0]      rsp_row_count;
   logic [ROW_W-1:0]      rsp_rect_width;
   logic                  rsp_last_of_run;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // Model copy of registers and region state
   logic [STRIDE_W-1:0]   geo_stride;
   logic [ROW_W-1:0]      geo_rows;
   logic [ROW_W-1:0]      geo_columns;
   logic [ROW_W-1:0]      open_first_row;
   logic [ROW_W-1:0]      open_end_row;
   logic [WORD_IDX_W-1:0] scan_word_index;

   rect_type expected_rects[$];
   int    mismatch_count = 0;
   int    burst_left = 0;
   bit    steady_sender = 0;
   int    hold_off_left = 0;

   dirty_page_row_coalescer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_dirty_word   (req_dirty_word),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_start    (rsp_row_start),
      .rsp_row_count    (rsp_row_count),
      .rsp_rect_width   (rsp_rect_width),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 100 MHz clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Run limit
   initial begin
      #15_000_000;
      $display("dirty_page_row_coalescer test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Row model
   // ---------------------------------------------------------------------
   function automatic rect_type make_rect(logic [ROW_W-1:0] first, logic [ROW_W-1:0] stop);
      rect_type r;
      r.row_start   = START_W'(first);
      r.row_count   = ROW_W'(stop - first);
      r.rect_width  = geo_columns;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Walk the set bits of one word and queue the rectangles it closes
   function automatic void predict_rects(logic [WORD_BITS-1:0] word, logic last);
      longint unsigned stride, rows, page, page_offset, y0, y1, reach;
      rect_type found[$];
      stride = (geo_stride == 0) ? 1 : geo_stride;
      rows   = (geo_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : geo_rows;
      for (int k = 0; k < WORD_BITS; k++) begin
         if (word[k]) begin
            page        = longint'(scan_word_index) * WORD_BITS + k;
            page_offset = page * PAGE_BYTES_DEF;
            y0          = page_offset / stride;
            // pages below the visible rows are dropped
            if (y0 < rows) begin
               y1 = (page_offset + PAGE_BYTES_DEF - 1) / stride + 1;
               if (y1 > rows)
                  y1 = rows;
               reach = open_end_row + MERGE_GAP_ROWS_DEF;
               if (open_first_row == open_end_row) begin
                  open_first_row = ROW_W'(y0);
                  open_end_row   = ROW_W'(y1);
               end else if (y0 <= reach) begin
                  if (y0 < open_first_row)
                     open_first_row = ROW_W'(y0);
                  if (y1 > open_end_row)
                     open_end_row = ROW_W'(y1);
               end else begin
                  found.push_back(make_rect(open_first_row, open_end_row));
                  open_first_row = ROW_W'(y0);
                  open_end_row   = ROW_W'(y1);
               end
            end
         end
      end
      if (last) begin
         if (open_first_row != open_end_row)
            found.push_back(make_rect(open_first_row, open_end_row));
         open_first_row  = '0;
         open_end_row    = '0;
         scan_word_index = '0;
      end else begin
         scan_word_index = scan_word_index + 1'b1;
      end
      if (found.size() > 0)
         found[found.size() - 1].last_of_run = 1'b1;
      foreach (found[i])
         expected_rects.push_back(found[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rect_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rects.size() == 0) begin
            $error("unexpected rectangle: row_start %0d row_count %0d",
                   rsp_row_start, rsp_row_count);
            mismatch_count++;
         end else begin
            want = expected_rects.pop_front();
            if (rsp_row_start !== want.row_start) begin
               $error("row_start: expected %0d, actual %0d", want.row_start, rsp_row_start);
               mismatch_count++;
            end
            if (rsp_row_count !== want.row_count) begin
               $error("row_count: expected %0d, actual %0d", want.row_count, rsp_row_count);
               mismatch_count++;
            end
            if (rsp_rect_width !== want.rect_width) begin
               $error("rect_width: expected %0d, actual %0d", want.rect_width, rsp_rect_width);
               mismatch_count++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, actual %0d",
                      want.last_of_run, rsp_last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: changing stall styles plus an on-demand long hold-off
   // ---------------------------------------------------------------------
   initial begin : receiver
      ready_style_type style;
      int style_left;
      int phase;
      rsp_ready  = 1'b0;
      style      = RDY_ALWAYS;
      style_left = 0;
      phase      = 0;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            style      = ready_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(16, 200);
         end
         style_left--;
         phase++;
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               RDY_ALWAYS:       rsp_ready <= 1'b1;
               RDY_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
               RDY_EVERY_FOURTH: rsp_ready <= (phase % 4 == 0);
               default:          rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request and register drivers
   // ---------------------------------------------------------------------
   // One request; bursty unless the sender is steady
   task automatic send_word(logic [WORD_BITS-1:0] word, logic last);
      int gap;
      if (!steady_sender && burst_left == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_dirty_word <= word;
      req_last_word  <= last;
      do @(posedge clock); while (!req_ready);
      predict_rects(word, last);
   endtask

   // Sender pauses until every rectangle is back and the block is quiet
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rects.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_LINE_STRIDE:    geo_stride  = STRIDE_W'(data);
         CSR_SCREEN_ROWS:    geo_rows    = ROW_W'(data);
         CSR_SCREEN_COLUMNS: geo_columns = ROW_W'(data);
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_geometry(int stride, int rows, int columns);
      wait_drained();
      write_csr(CSR_LINE_STRIDE, CSR_DATA_W'(stride));
      write_csr(CSR_SCREEN_ROWS, CSR_DATA_W'(rows));
      write_csr(CSR_SCREEN_COLUMNS, CSR_DATA_W'(columns));
   endtask

   function automatic logic [WORD_BITS-1:0] random_dirty_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return $urandom;
         2:       return $urandom & $urandom & $urandom;
         3:       return '1;
         4:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom | $urandom;
      endcase
   endfunction

   // Scans of random length; a few end without the last flag and run on
   task automatic send_random_scans(int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(1, 12);
         if (len > items - sent)
            len = items - sent;
         for (int i = 0; i < len; i++)
            send_word(random_dirty_word(), (i == len - 1) && ($urandom_range(0, 7) != 0));
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset geometry 2560 / 480 / 640
   task automatic test_default_geometry();
      send_word(32'h0000_0001, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h8000_0001, 1'b1);
      // word nine straddles the bottom of the screen
      repeat (9) send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_random_scans(45);
   endtask

   // One row per page: gap of three merges, gap of four splits
   task automatic test_merge_gap();
      set_geometry(4096, 4096, 4096);
      send_word(32'h0000_0011, 1'b1);
      send_word(32'h0000_0021, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_random_scans(30);
   endtask

   // Stride of four, rows above the clamp, width of one
   task automatic test_min_stride_tall_screen();
      set_geometry(4, 8191, 1);
      send_word(32'h0000_000F, 1'b1);
      send_word(32'h0000_0005, 1'b1);
      send_word(32'hFFFF_FFF0, 1'b1);
      send_random_scans(15);
   endtask

   // Widest stride, single visible row, zero width
   task automatic test_max_stride_single_row();
      set_geometry(32767, 1, 0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_random_scans(10);
   endtask

   // Zero stride acts as one byte per row
   task automatic test_zero_stride();
      set_geometry(0, 4096, 8191);
      send_word(32'h0000_0002, 1'b1);
      send_word(32'h0000_0001, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_random_scans(10);
   endtask

   // No visible rows, then a tall screen with four pages per row
   task automatic test_zero_rows();
      set_geometry(16384, 0, 640);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      set_geometry(16384, 4096, 640);
      send_random_scans(20);
   endtask

   task automatic test_random_geometry();
      repeat (3) begin
         set_geometry($urandom_range(4, 16384), $urandom_range(1, 4096),
                      $urandom_range(0, 8191));
         send_random_scans(15);
      end
   endtask

   // Receiver holds off while the sender keeps offering requests
   task automatic test_backpressure();
      set_geometry(2560, 480, 640);
      steady_sender = 1;
      hold_off_left = 3000;
      repeat (3) send_word(32'h8888_8888, 1'b0);
      send_word(32'h1111_1111, 1'b1);
      repeat (2) send_word(32'h8080_8080, 1'b1);
      wait_drained();
      send_random_scans(20);
      steady_sender = 0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_dirty_word   = '0;
      req_last_word    = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_LINE_STRIDE;
      csr_write_data   = '0;
      geo_stride       = STRIDE_RST;
      geo_rows         = ROWS_RST;
      geo_columns      = COLUMNS_RST;
      open_first_row   = '0;
      open_end_row     = '0;
      scan_word_index  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_geometry();
      test_merge_gap();
      test_min_stride_tall_screen();
      test_max_stride_single_row();
      test_zero_stride();
      test_zero_rows();
      test_random_geometry();
      test_backpressure();
      wait_drained();

      if (mismatch_count == 0)
         $display("dirty_page_row_coalescer test passed");
      else
         $display("dirty_page_row_coalescer test failed");
      $finish;
   end

endmodule
